FILE: sv/aoc_pkg.sv
// ----------------------------------------------------------------------------
// aoc_pkg: shared types and constants of the alpha-over compositor
// Beat formats of both channels, Q1.15 constants and pipeline stage indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package aoc_pkg;

  // Q1.15 unsigned: 32768 stands for 1.0
  localparam logic [15:0] Q_ONE    = 16'h8000;
  localparam int          NUM_CH   = 3;
  localparam int          DIV_BITS = 16;

  // Operation codes of the input beat
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  // Pipeline stage indexes
  localparam int ST_CLAMP   = 0;
  localparam int ST_MUL1    = 1;
  localparam int ST_MUL2    = 2;
  localparam int ST_NUM     = 3;
  localparam int ST_OVF     = 4;
  localparam int ST_DIV0    = 5;
  localparam int ST_OUT     = ST_DIV0 + DIV_BITS;
  localparam int NUM_STAGES = ST_OUT + 1;

  typedef struct packed {
    logic        operation;
    logic [15:0] lhs_red;
    logic [15:0] lhs_green;
    logic [15:0] lhs_blue;
    logic [15:0] lhs_alpha;
    logic [15:0] rhs_red;
    logic [15:0] rhs_green;
    logic [15:0] rhs_blue;
    logic [15:0] rhs_alpha;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic        fully_transparent;
  } out_beat_t;

  // Saturate a raw 16-bit field to 1.0
  function automatic logic [15:0] clamp_one(input logic [15:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/alpha_over_compositor_top.sv
// ----------------------------------------------------------------------------
// alpha_over_compositor_top: straight-alpha "over" compositing in Q1.15
// Composites the lhs pixel over the rhs pixel, add or subtract of rhs color.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  in_valid / in_stall / in_data  : one pixel pair per beat.
//   Output channel out_valid / out_stall / out_data : one composited pixel.
//   A beat moves at a rising edge with valid high and stall low.
//   Stages from input beat to output valid, in order: clamp, two multiply
//   stages, numerator, range check, 16 one-bit restoring divide stages
//   sharing nothing, output register.
//   Throughput: one pixel per clock unless stalled; the restoring divider is
//   unrolled into one register stage per quotient bit, so nothing iterates.
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles squeeze out and in_stall rises only once every stage holds a
//   beat and the receiver stalls.
//   Reset (rst_n low, synchronous) drops every beat in flight; data
//   registers are not cleared.
//   When the combined alpha is zero the lhs color passes unchanged,
//   out_alpha is zero and fully_transparent is set.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_over_compositor_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire aoc_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output aoc_pkg::out_beat_t      out_data
);

  // Clamped operands
  typedef struct packed {
    logic                                  sub;
    logic [aoc_pkg::NUM_CH-1:0][15:0]      raw;
    logic [aoc_pkg::NUM_CH-1:0][15:0]      c1;
    logic [aoc_pkg::NUM_CH-1:0][15:0]      c2;
    logic [15:0]                           a1;
    logic [15:0]                           a2;
    logic [15:0]                           ia1;
    logic [15:0]                           ia2;
  } clamp_t;

  // First products
  typedef struct packed {
    logic                                  sub;
    logic [aoc_pkg::NUM_CH-1:0][15:0]      raw;
    logic [aoc_pkg::NUM_CH-1:0][15:0]      c2;
    logic [aoc_pkg::NUM_CH-1:0][30:0]      p1;
    logic [30:0]                           pa;
    logic [30:0]                           pw;
  } mul1_t;

  // Weighted rhs products and combined alpha
  typedef struct packed {
    logic                                  sub;
    logic [aoc_pkg::NUM_CH-1:0][15:0]      raw;
    logic [aoc_pkg::NUM_CH-1:0][30:0]      p1;
    logic [aoc_pkg::NUM_CH-1:0][30:0]      p2;
    logic [15:0]                           oa;
  } mul2_t;

  // Divider state, one per stage, with a remainder and quotient per channel
  typedef struct packed {
    logic                                  transp;
    logic [aoc_pkg::NUM_CH-1:0][15:0]      raw;
    logic [15:0]                           oa;
    logic [aoc_pkg::NUM_CH-1:0][31:0]      rem;
    logic [aoc_pkg::NUM_CH-1:0][15:0]      q;
    logic [aoc_pkg::NUM_CH-1:0]            ovf;
  } div_t;

  logic [aoc_pkg::NUM_STAGES-1:0] vld_r;
  logic [aoc_pkg::NUM_STAGES-1:0] adv;

  clamp_t             clamp_r, clamp_nxt;
  mul1_t              mul1_r, mul1_nxt;
  mul2_t              mul2_r, mul2_nxt;
  div_t               div_r   [aoc_pkg::ST_NUM:aoc_pkg::ST_OUT-1];
  div_t               div_nxt [aoc_pkg::ST_NUM:aoc_pkg::ST_OUT-1];
  aoc_pkg::out_beat_t out_r, out_nxt;

  // --------------------------------------------------------------------------
  // Flow control: a stage takes a new beat when it is empty or its beat moves
  // on. The last stage moves on when the receiver does not stall.
  // --------------------------------------------------------------------------
  always_comb begin
    adv[aoc_pkg::NUM_STAGES-1] = !vld_r[aoc_pkg::NUM_STAGES-1] || !out_stall;
    for (int k = aoc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[aoc_pkg::ST_CLAMP];
  assign out_valid = vld_r[aoc_pkg::ST_OUT];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < aoc_pkg::NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: clamp every field to 1.0, form the alpha complements.
  // Keep the raw lhs color for the transparent pass-through.
  // --------------------------------------------------------------------------
  always_comb begin
    clamp_nxt.sub    = (in_data.operation == aoc_pkg::OP_SUB);
    clamp_nxt.raw[0] = in_data.lhs_red;
    clamp_nxt.raw[1] = in_data.lhs_green;
    clamp_nxt.raw[2] = in_data.lhs_blue;
    clamp_nxt.c1[0]  = aoc_pkg::clamp_one(in_data.lhs_red);
    clamp_nxt.c1[1]  = aoc_pkg::clamp_one(in_data.lhs_green);
    clamp_nxt.c1[2]  = aoc_pkg::clamp_one(in_data.lhs_blue);
    clamp_nxt.c2[0]  = aoc_pkg::clamp_one(in_data.rhs_red);
    clamp_nxt.c2[1]  = aoc_pkg::clamp_one(in_data.rhs_green);
    clamp_nxt.c2[2]  = aoc_pkg::clamp_one(in_data.rhs_blue);
    clamp_nxt.a1     = aoc_pkg::clamp_one(in_data.lhs_alpha);
    clamp_nxt.a2     = aoc_pkg::clamp_one(in_data.rhs_alpha);
    clamp_nxt.ia1    = aoc_pkg::Q_ONE - clamp_nxt.a1;
    clamp_nxt.ia2    = aoc_pkg::Q_ONE - clamp_nxt.a2;
  end

  // --------------------------------------------------------------------------
  // Stage 1: lhs color times lhs alpha, the alpha complement product and the
  // unshifted rhs weight. All operands are at most 1.0, so 31 bits hold each.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [aoc_pkg::NUM_CH-1:0][31:0] p1_full;
    logic [31:0]                      pa_full;
    logic [31:0]                      pw_full;
    for (int ch = 0; ch < aoc_pkg::NUM_CH; ch++) begin
      p1_full[ch] = 32'(clamp_r.c1[ch]) * 32'(clamp_r.a1);
    end
    pa_full = 32'(clamp_r.ia1) * 32'(clamp_r.ia2);
    pw_full = 32'(clamp_r.a2) * 32'(clamp_r.ia1);
    mul1_nxt.sub = clamp_r.sub;
    mul1_nxt.raw = clamp_r.raw;
    mul1_nxt.c2  = clamp_r.c2;
    for (int ch = 0; ch < aoc_pkg::NUM_CH; ch++) begin
      mul1_nxt.p1[ch] = p1_full[ch][30:0];
    end
    mul1_nxt.pa = pa_full[30:0];
    mul1_nxt.pw = pw_full[30:0];
  end

  // --------------------------------------------------------------------------
  // Stage 2: combined alpha, and rhs color times its weight (w1 = pw >> 15).
  // --------------------------------------------------------------------------
  always_comb begin
    logic [aoc_pkg::NUM_CH-1:0][31:0] p2_full;
    for (int ch = 0; ch < aoc_pkg::NUM_CH; ch++) begin
      p2_full[ch] = 32'(mul1_r.c2[ch]) * 32'(mul1_r.pw[30:15]);
    end
    mul2_nxt.sub = mul1_r.sub;
    mul2_nxt.raw = mul1_r.raw;
    mul2_nxt.p1  = mul1_r.p1;
    for (int ch = 0; ch < aoc_pkg::NUM_CH; ch++) begin
      mul2_nxt.p2[ch] = p2_full[ch][30:0];
    end
    mul2_nxt.oa = aoc_pkg::Q_ONE - mul1_r.pa[30:15];
  end

  // --------------------------------------------------------------------------
  // Numerator, range check and restoring divide, one quotient bit per stage.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [31:0] dsh;
    logic [31:0] lim;
    dsh = '0;
    lim = '0;

    // Numerator: drop to zero when a subtraction does not stay positive
    div_nxt[aoc_pkg::ST_NUM].transp = (mul2_r.oa == '0);
    div_nxt[aoc_pkg::ST_NUM].raw    = mul2_r.raw;
    div_nxt[aoc_pkg::ST_NUM].oa     = mul2_r.oa;
    div_nxt[aoc_pkg::ST_NUM].q      = '0;
    div_nxt[aoc_pkg::ST_NUM].ovf    = '0;
    for (int ch = 0; ch < aoc_pkg::NUM_CH; ch++) begin
      if (!mul2_r.sub) begin
        div_nxt[aoc_pkg::ST_NUM].rem[ch] = 32'(mul2_r.p1[ch]) + 32'(mul2_r.p2[ch]);
      end else if (mul2_r.p1[ch] > mul2_r.p2[ch]) begin
        div_nxt[aoc_pkg::ST_NUM].rem[ch] = 32'(mul2_r.p1[ch]) - 32'(mul2_r.p2[ch]);
      end else begin
        div_nxt[aoc_pkg::ST_NUM].rem[ch] = '0;
      end
    end

    // Quotient of 2^16 or more saturates; flag it so 16 bits suffice below
    div_nxt[aoc_pkg::ST_OVF] = div_r[aoc_pkg::ST_NUM];
    lim = {div_r[aoc_pkg::ST_NUM].oa, 16'b0};
    for (int ch = 0; ch < aoc_pkg::NUM_CH; ch++) begin
      div_nxt[aoc_pkg::ST_OVF].ovf[ch] = (div_r[aoc_pkg::ST_NUM].rem[ch] >= lim);
    end

    // Restoring steps, most significant quotient bit first
    for (int k = aoc_pkg::ST_DIV0; k < aoc_pkg::ST_OUT; k++) begin
      div_nxt[k] = div_r[k-1];
      dsh = 32'(div_r[k-1].oa) << (aoc_pkg::ST_OUT - 1 - k);
      for (int ch = 0; ch < aoc_pkg::NUM_CH; ch++) begin
        if (div_r[k-1].rem[ch] >= dsh) begin
          div_nxt[k].rem[ch] = div_r[k-1].rem[ch] - dsh;
          div_nxt[k].q[ch][aoc_pkg::ST_OUT-1-k] = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: saturate the quotient to 1.0, or pass the lhs color through
  // when the combined alpha is zero (out_alpha is zero then as well).
  // --------------------------------------------------------------------------
  always_comb begin
    logic [aoc_pkg::NUM_CH-1:0][15:0] col;
    for (int ch = 0; ch < aoc_pkg::NUM_CH; ch++) begin
      if (div_r[aoc_pkg::ST_OUT-1].transp) begin
        col[ch] = div_r[aoc_pkg::ST_OUT-1].raw[ch];
      end else if (div_r[aoc_pkg::ST_OUT-1].ovf[ch] ||
                   div_r[aoc_pkg::ST_OUT-1].q[ch] > aoc_pkg::Q_ONE) begin
        col[ch] = aoc_pkg::Q_ONE;
      end else begin
        col[ch] = div_r[aoc_pkg::ST_OUT-1].q[ch];
      end
    end
    out_nxt.out_red           = col[0];
    out_nxt.out_green         = col[1];
    out_nxt.out_blue          = col[2];
    out_nxt.out_alpha         = div_r[aoc_pkg::ST_OUT-1].oa;
    out_nxt.fully_transparent = div_r[aoc_pkg::ST_OUT-1].transp;
  end

  // Payload registers: load on advance, hold otherwise
  always_ff @(posedge clk) begin
    if (adv[aoc_pkg::ST_CLAMP]) begin
      clamp_r <= clamp_nxt;
    end
    if (adv[aoc_pkg::ST_MUL1]) begin
      mul1_r <= mul1_nxt;
    end
    if (adv[aoc_pkg::ST_MUL2]) begin
      mul2_r <= mul2_nxt;
    end
    for (int k = aoc_pkg::ST_NUM; k < aoc_pkg::ST_OUT; k++) begin
      if (adv[k]) begin
        div_r[k] <= div_nxt[k];
      end
    end
    if (adv[aoc_pkg::ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input stalls only when every stage is full and the receiver holds off
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline still had room");

  // Transparent result carries zero alpha
  a_transp_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.fully_transparent) |-> (out_data.out_alpha == '0))
    else $error("transparent beat with nonzero alpha");

  // Opaque result carries nonzero alpha
  a_opaque_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.fully_transparent) |-> (out_data.out_alpha != '0))
    else $error("composited beat with zero alpha");

  // Composited colors never exceed 1.0
  a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.fully_transparent) |->
      (out_data.out_red <= aoc_pkg::Q_ONE && out_data.out_green <= aoc_pkg::Q_ONE &&
       out_data.out_blue <= aoc_pkg::Q_ONE))
    else $error("composited color above 1.0");

endmodule

`default_nettype wire
